// File: sv/obb_overlap_axis_test_assert.svh
// Assertion macros used by the RTL file obb_overlap_axis_test.sv.
`ifndef OBB_OVERLAP_AXIS_TEST_ASSERT_SVH
`define OBB_OVERLAP_AXIS_TEST_ASSERT_SVH
`ifndef ASSERT_OFF
`define OBBO_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define OBBO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define OBBO_ASSERT(lbl, clk, rst_n, ante, cons)
`define OBBO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/obbo_pkg.sv
package obbo_pkg;
  localparam int unsigned COMPONENT_BITS     = 16;
  localparam int unsigned AXIS_FRACTION_BITS = 14;
  localparam int unsigned FIELD_BITS         = 48;
  localparam int unsigned NUM_AXES           = 15;
  localparam int unsigned NUM_BOX_AXES       = 6;
  localparam int unsigned NUM_COMP           = 3;
  localparam int unsigned NUM_CROSS          = 9;
  localparam int unsigned NUM_STAGES         = 8;

  typedef struct packed {
    logic s4;
    logic s5;
    logic s6;
    logic s7;
  } stage_en_t;
endpackage

// File: sv/obbo_in_if.sv
interface obbo_in_if;
  import obbo_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] a_center;
  logic [FIELD_BITS-1:0] a_axis_x;
  logic [FIELD_BITS-1:0] a_axis_y;
  logic [FIELD_BITS-1:0] a_axis_z;
  logic [FIELD_BITS-1:0] a_half;
  logic [FIELD_BITS-1:0] b_center;
  logic [FIELD_BITS-1:0] b_axis_x;
  logic [FIELD_BITS-1:0] b_axis_y;
  logic [FIELD_BITS-1:0] b_axis_z;
  logic [FIELD_BITS-1:0] b_half;

  modport source (output valid, a_center, a_axis_x, a_axis_y, a_axis_z, a_half,
                  b_center, b_axis_x, b_axis_y, b_axis_z, b_half, input ready);
  modport sink (input valid, a_center, a_axis_x, a_axis_y, a_axis_z, a_half,
                b_center, b_axis_x, b_axis_y, b_axis_z, b_half, output ready);
endinterface

// File: sv/obbo_out_if.sv
interface obbo_out_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink (input valid, overlap, output ready);
endinterface

// File: sv/obb_overlap_axis_test.sv
// Separating-axis overlap test for two oriented boxes.
// The input channel carries one word per box pair: the center, three axes
// and three half extents of each box. The output channel returns one word
// per input word with a single overlap flag, in the same order.
// The datapath is an eight-stage pipeline: unpack, cross-product multiply,
// cross-product subtract, projection multiply, projection sum, half-extent
// multiply, per-axis compare and the final combine of all 15 axes.
// One word can be accepted in every clock cycle unless all stages hold a
// word and the output is not taken.
// Each stage holds its word until the next stage can take it, so empty
// stages fill while the receiver stalls; input ready falls only once all
// stages hold a word and the output is not taken. No word is lost or repeated.
// Reset clears all valid bits; the pipeline is ready right after reset.
`include "obb_overlap_axis_test_assert.svh"

module obb_overlap_axis_test #(
  parameter int unsigned COMPONENT_BITS     = obbo_pkg::COMPONENT_BITS,
  parameter int unsigned AXIS_FRACTION_BITS = obbo_pkg::AXIS_FRACTION_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  obbo_in_if.sink    in_i,
  obbo_out_if.source out_o
);
  import obbo_pkg::*;

  localparam int unsigned C   = COMPONENT_BITS;
  localparam int unsigned PW  = 3 * C;
  localparam int unsigned TW  = C + 1;
  localparam int unsigned PPW = 2 * C;
  localparam int unsigned LW  = 2 * C + 1;

  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] v_d;
  logic [NUM_STAGES:0]   adv;

  logic [PW-1:0]         wax [NUM_BOX_AXES];
  logic [PW-1:0]         wh [2];
  logic [PW-1:0]         wca;
  logic [PW-1:0]         wcb;

  logic signed [C-1:0]   ax_d [NUM_BOX_AXES][NUM_COMP];
  logic        [C-1:0]   h_d [NUM_BOX_AXES];
  logic signed [TW-1:0]  t_d [NUM_COMP];

  logic signed [C-1:0]   ax_q [3][NUM_BOX_AXES][NUM_COMP];
  logic        [C-1:0]   h_q [5][NUM_BOX_AXES];
  logic signed [TW-1:0]  t_q [3][NUM_COMP];
  logic signed [PPW-1:0] pp_q [NUM_CROSS][NUM_COMP][2];
  logic signed [LW-1:0]  l_q [NUM_AXES][NUM_COMP];
  logic [NUM_AXES-1:0]   sep;
  logic                  overlap_q;
  stage_en_t             en;

  // A stage loads when it is empty or the stage after it moves on.
  always_comb begin
    adv[NUM_STAGES] = out_o.ready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      adv[i] = !v_q[i] || adv[i+1];
    end
    v_d[0] = adv[0] ? in_i.valid : v_q[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (adv[i]) begin
        v_d[i] = v_q[i-1];
      end else begin
        v_d[i] = v_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_i.ready = adv[0];

  // Bits beyond the 48-bit field read as zero.
  always_comb begin
    wax[0] = PW'(in_i.a_axis_x);
    wax[1] = PW'(in_i.a_axis_y);
    wax[2] = PW'(in_i.a_axis_z);
    wax[3] = PW'(in_i.b_axis_x);
    wax[4] = PW'(in_i.b_axis_y);
    wax[5] = PW'(in_i.b_axis_z);
    wh[0]  = PW'(in_i.a_half);
    wh[1]  = PW'(in_i.b_half);
    wca    = PW'(in_i.a_center);
    wcb    = PW'(in_i.b_center);
    for (int k = 0; k < NUM_BOX_AXES; k++) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        ax_d[k][c] = signed'(wax[k][c*C +: C]);
      end
      h_d[k] = wh[k/3][(k%3)*C +: C];
    end
    for (int c = 0; c < NUM_COMP; c++) begin
      t_d[c] = TW'(signed'(wca[c*C +: C])) - TW'(signed'(wcb[c*C +: C]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      ax_q[0] <= ax_d;
      h_q[0]  <= h_d;
      t_q[0]  <= t_d;
    end
    for (int s = 1; s < 3; s++) begin
      if (adv[s]) begin
        ax_q[s] <= ax_q[s-1];
        t_q[s]  <= t_q[s-1];
      end
    end
    for (int s = 1; s < 5; s++) begin
      if (adv[s]) begin
        h_q[s] <= h_q[s-1];
      end
    end
  end

  // Cross axes: (A axis i) x (B axis j), products first, differences next.
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pp_q[i*3+j][0][0] <= PPW'(ax_q[0][i][1]) * PPW'(ax_q[0][3+j][2]);
          pp_q[i*3+j][0][1] <= PPW'(ax_q[0][i][2]) * PPW'(ax_q[0][3+j][1]);
          pp_q[i*3+j][1][0] <= PPW'(ax_q[0][i][2]) * PPW'(ax_q[0][3+j][0]);
          pp_q[i*3+j][1][1] <= PPW'(ax_q[0][i][0]) * PPW'(ax_q[0][3+j][2]);
          pp_q[i*3+j][2][0] <= PPW'(ax_q[0][i][0]) * PPW'(ax_q[0][3+j][1]);
          pp_q[i*3+j][2][1] <= PPW'(ax_q[0][i][1]) * PPW'(ax_q[0][3+j][0]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        for (int k = 0; k < NUM_BOX_AXES; k++) begin
          l_q[k][c] <= LW'(ax_q[1][k][c]);
        end
        for (int m = 0; m < NUM_CROSS; m++) begin
          l_q[NUM_BOX_AXES+m][c] <= LW'(pp_q[m][c][0]) - LW'(pp_q[m][c][1]);
        end
      end
    end
  end

  assign en.s4 = adv[3];
  assign en.s5 = adv[4];
  assign en.s6 = adv[5];
  assign en.s7 = adv[6];

  for (genvar n = 0; n < NUM_AXES; n++) begin : g_axis
    obbo_axis_unit #(
      .COMPONENT_BITS     (COMPONENT_BITS),
      .AXIS_FRACTION_BITS (AXIS_FRACTION_BITS)
    ) u_axis (
      .clk_i (clk_i),
      .en_i  (en),
      .l_i   (l_q[n]),
      .t_i   (t_q[2]),
      .ax_i  (ax_q[2]),
      .h_i   (h_q[4]),
      .sep_o (sep[n])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      overlap_q <= ~|sep;
    end
  end

  assign out_o.valid   = v_q[NUM_STAGES-1];
  assign out_o.overlap = overlap_q;

  `OBBO_ASSERT(a_empty_out_ready, clk_i, rst_ni, !out_o.valid, in_i.ready)
  `OBBO_ASSERT(a_full_stall, clk_i, rst_ni, (&v_q) && !out_o.ready, !in_i.ready)
  `OBBO_ASSERT_NEXT(a_accept_fills, clk_i, rst_ni, in_i.valid && in_i.ready, v_q[0])
endmodule

// File: sv/obbo_axis_unit.sv
module obbo_axis_unit #(
  parameter int unsigned COMPONENT_BITS     = obbo_pkg::COMPONENT_BITS,
  parameter int unsigned AXIS_FRACTION_BITS = obbo_pkg::AXIS_FRACTION_BITS
) (
  input  logic                                clk_i,
  input  obbo_pkg::stage_en_t                 en_i,
  input  logic signed [2*COMPONENT_BITS:0]    l_i [obbo_pkg::NUM_COMP],
  input  logic signed [COMPONENT_BITS:0]      t_i [obbo_pkg::NUM_COMP],
  input  logic signed [COMPONENT_BITS-1:0]
                      ax_i [obbo_pkg::NUM_BOX_AXES][obbo_pkg::NUM_COMP],
  input  logic        [COMPONENT_BITS-1:0]    h_i [obbo_pkg::NUM_BOX_AXES],
  output logic                                sep_o
);
  import obbo_pkg::*;

  localparam int unsigned C    = COMPONENT_BITS;
  localparam int unsigned F    = AXIS_FRACTION_BITS;
  localparam int unsigned TW   = C + 1;
  localparam int unsigned LW   = 2 * C + 1;
  localparam int unsigned TPW  = TW + LW;
  localparam int unsigned APW  = C + LW;
  localparam int unsigned DW   = TPW + 2;
  localparam int unsigned AW   = APW + 2;
  localparam int unsigned HPW  = AW + C;
  localparam int unsigned RW   = HPW + 3;
  localparam int unsigned LHW  = DW + F;
  localparam int unsigned CMW  = (LHW > RW) ? LHW : RW;

  logic signed [TPW-1:0] tp_q [NUM_COMP];
  logic signed [APW-1:0] ap_q [NUM_BOX_AXES][NUM_COMP];
  logic        [DW-1:0]  td_q;
  logic        [AW-1:0]  ad_q [NUM_BOX_AXES];
  logic        [LHW-1:0] lhs_q;
  logic        [HPW-1:0] hp_q [NUM_BOX_AXES];
  logic                  sep_q;

  logic signed [DW-1:0]  tsum_d;
  logic        [DW-1:0]  td_d;
  logic signed [AW-1:0]  asum_d [NUM_BOX_AXES];
  logic        [AW-1:0]  ad_d [NUM_BOX_AXES];
  logic        [RW-1:0]  rhs_d;
  logic                  sep_d;

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        tp_q[c] <= TPW'(t_i[c]) * TPW'(l_i[c]);
        for (int k = 0; k < NUM_BOX_AXES; k++) begin
          ap_q[k][c] <= APW'(ax_i[k][c]) * APW'(l_i[c]);
        end
      end
    end
  end

  // Signed sum of three products, then magnitude.
  always_comb begin
    tsum_d = DW'(tp_q[0]) + DW'(tp_q[1]) + DW'(tp_q[2]);
    td_d   = tsum_d[DW-1] ? DW'(-tsum_d) : DW'(tsum_d);
    for (int k = 0; k < NUM_BOX_AXES; k++) begin
      asum_d[k] = AW'(ap_q[k][0]) + AW'(ap_q[k][1]) + AW'(ap_q[k][2]);
      ad_d[k]   = asum_d[k][AW-1] ? AW'(-asum_d[k]) : AW'(asum_d[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      td_q <= td_d;
      for (int k = 0; k < NUM_BOX_AXES; k++) begin
        ad_q[k] <= ad_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s6) begin
      lhs_q <= LHW'(td_q) << F;
      for (int k = 0; k < NUM_BOX_AXES; k++) begin
        hp_q[k] <= HPW'(ad_q[k]) * HPW'(h_i[k]);
      end
    end
  end

  // The axis separates when the scaled center distance exceeds the radius sum.
  always_comb begin
    rhs_d = '0;
    for (int k = 0; k < NUM_BOX_AXES; k++) begin
      rhs_d = rhs_d + RW'(hp_q[k]);
    end
    sep_d = CMW'(lhs_q) > CMW'(rhs_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s7) begin
      sep_q <= sep_d;
    end
  end

  assign sep_o = sep_q;
endmodule

// File: test/obb_overlap_axis_test_test.sv
module obb_overlap_axis_test_test;
  import obbo_pkg::*;

  localparam int C = COMPONENT_BITS;
  localparam int F = AXIS_FRACTION_BITS;
  localparam int NUM_RANDOM = 430;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [FIELD_BITS-1:0] w[10];
  } box_pair_t;

  typedef struct {
    logic [FIELD_BITS-1:0] w[10];
    int                    want;
  } vector_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  obbo_in_if  pair_if ();
  obbo_out_if flag_if ();

  obb_overlap_axis_test u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pair_if.sink),
    .out_o (flag_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bit   overlap_q[$];
  int   errors = 0;
  int   flags_seen = 0;
  int   overlaps_seen = 0;
  int   cycles = 0;
  int   rx_wait = 0;
  logic unused_ok;

  function automatic logic signed [C:0] comp_s(logic [FIELD_BITS-1:0] w, int i);
    logic [C-1:0] r;
    r = w[i*C +: C];
    return $signed({r[C-1], r});
  endfunction

  function automatic logic signed [127:0] abs128(logic signed [127:0] x);
    return (x < 0) ? -x : x;
  endfunction

  // Exact integer separating-axis test over all 15 candidate axes.
  function automatic bit boxes_overlap(box_pair_t p);
    logic signed [127:0] ax[6][3];
    logic signed [127:0] hv[6];
    logic signed [127:0] tv[3];
    logic signed [127:0] lv[15][3];
    logic signed [127:0] lhs, rhs, d;
    int n;
    n = 6;
    for (int b = 0; b < 2; b++) begin
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 3; c++) ax[b*3+k][c] = comp_s(p.w[b*5+1+k], c);
        hv[b*3+k] = {112'd0, p.w[b*5+4][k*C +: C]};
      end
    end
    for (int c = 0; c < 3; c++) tv[c] = comp_s(p.w[0], c) - comp_s(p.w[5], c);
    for (int k = 0; k < 6; k++)
      for (int c = 0; c < 3; c++) lv[k][c] = ax[k][c];
    for (int i = 0; i < 3; i++) begin
      for (int j = 3; j < 6; j++) begin
        lv[n][0] = ax[i][1]*ax[j][2] - ax[i][2]*ax[j][1];
        lv[n][1] = ax[i][2]*ax[j][0] - ax[i][0]*ax[j][2];
        lv[n][2] = ax[i][0]*ax[j][1] - ax[i][1]*ax[j][0];
        n++;
      end
    end
    for (int a = 0; a < 15; a++) begin
      lhs = abs128(tv[0]*lv[a][0] + tv[1]*lv[a][1] + tv[2]*lv[a][2]) <<< F;
      rhs = 0;
      for (int k = 0; k < 6; k++) begin
        d = abs128(ax[k][0]*lv[a][0] + ax[k][1]*lv[a][1] + ax[k][2]*lv[a][2]);
        rhs += d * hv[k];
      end
      if (lhs > rhs) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [FIELD_BITS-1:0] vec3(int x, int y, int z);
    logic [C-1:0] cx, cy, cz;
    cx = C'(x);
    cy = C'(y);
    cz = C'(z);
    return {cz, cy, cx};
  endfunction

  function automatic logic [FIELD_BITS-1:0] rand_word();
    return FIELD_BITS'({$urandom(), $urandom()});
  endfunction

  function automatic logic [FIELD_BITS-1:0] rand_unit_axis(int k);
    int one;
    one = (1 << F) - $urandom_range(0, 300);
    case (k)
      0: return vec3(one, $urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300);
      1: return vec3($urandom_range(0, 600) - 300, one, $urandom_range(0, 600) - 300);
      default: return vec3($urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300, one);
    endcase
  endfunction

  task automatic send_pair(box_pair_t p);
    int gap;
    gap = $urandom_range(0, 8);
    if (gap > 0) begin
      pair_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pair_if.valid    <= 1'b1;
    pair_if.a_center <= p.w[0];
    pair_if.a_axis_x <= p.w[1];
    pair_if.a_axis_y <= p.w[2];
    pair_if.a_axis_z <= p.w[3];
    pair_if.a_half   <= p.w[4];
    pair_if.b_center <= p.w[5];
    pair_if.b_axis_x <= p.w[6];
    pair_if.b_axis_y <= p.w[7];
    pair_if.b_axis_z <= p.w[8];
    pair_if.b_half   <= p.w[9];
    do @(posedge clk_i); while (!pair_if.ready);
  endtask

  task automatic send_checked(box_pair_t p, int want);
    bit pred;
    pred = boxes_overlap(p);
    if (want >= 0 && pred != want[0]) begin
      $display("%0t table row mismatch: expected %0d predicted %0d", $time, want, pred);
      errors++;
    end
    overlap_q.push_back(pred);
    send_pair(p);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && flag_if.valid && flag_if.ready) begin
      flags_seen++;
      if (flag_if.overlap) overlaps_seen++;
      if (overlap_q.size() == 0) begin
        $display("%0t unexpected word: overlap %0b", $time, flag_if.overlap);
        errors++;
      end else begin
        unused_ok = overlap_q.pop_front();
        if (flag_if.overlap !== unused_ok) begin
          $display("%0t overlap mismatch: expected %0b actual %0b", $time,
                   unused_ok, flag_if.overlap);
          errors++;
        end
      end
    end
  end

  // The receiver waits a freshly drawn number of cycles after each word.
  always @(posedge clk_i) begin
    if (flag_if.valid && flag_if.ready) begin
      rx_wait = $urandom_range(0, 8);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    flag_if.ready <= (rx_wait == 0);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    vector_row_t rows[$];
    box_pair_t   p;
    int          u, h;
    u = 1 << F;
    h = 256;
    pair_if.valid = 1'b0;
    pair_if.a_center = '0; pair_if.a_axis_x = '0; pair_if.a_axis_y = '0;
    pair_if.a_axis_z = '0; pair_if.a_half = '0; pair_if.b_center = '0;
    pair_if.b_axis_x = '0; pair_if.b_axis_y = '0; pair_if.b_axis_z = '0;
    pair_if.b_half = '0;
    flag_if.ready = 1'b1;

    // Unit cubes: coincident, touching, separated; then zero-size boxes and extreme centers.
    rows.push_back('{'{vec3(0,0,0), vec3(u,0,0), vec3(0,u,0), vec3(0,0,u), vec3(h,h,h),
                       vec3(0,0,0), vec3(u,0,0), vec3(0,u,0), vec3(0,0,u), vec3(h,h,h)}, 1});
    rows.push_back('{'{vec3(0,0,0), vec3(u,0,0), vec3(0,u,0), vec3(0,0,u), vec3(h,h,h),
                       vec3(2*h,0,0), vec3(u,0,0), vec3(0,u,0), vec3(0,0,u), vec3(h,h,h)}, 1});
    rows.push_back('{'{vec3(0,0,0), vec3(u,0,0), vec3(0,u,0), vec3(0,0,u), vec3(h,h,h),
                       vec3(2*h+1,0,0), vec3(u,0,0), vec3(0,u,0), vec3(0,0,u), vec3(h,h,h)}, 0});
    rows.push_back('{'{vec3(0,0,0), vec3(u,0,0), vec3(0,u,0), vec3(0,0,u), vec3(0,0,0),
                       vec3(0,0,1), vec3(u,0,0), vec3(0,u,0), vec3(0,0,u), vec3(0,0,0)}, 0});
    rows.push_back('{'{vec3(0,0,0), vec3(0,0,0), vec3(0,0,0), vec3(0,0,0), vec3(0,0,0),
                       vec3(-32768,32767,-1), vec3(0,0,0), vec3(0,0,0), vec3(0,0,0),
                       vec3(0,0,0)}, 1});
    rows.push_back('{'{vec3(32767,32767,32767), vec3(u,0,0), vec3(0,u,0), vec3(0,0,u),
                       vec3(65535,65535,65535), vec3(-32768,-32768,-32768), vec3(u,0,0),
                       vec3(0,u,0), vec3(0,0,u), vec3(65535,65535,65535)}, 1});
    rows.push_back('{'{vec3(32767,32767,32767), vec3(u,0,0), vec3(0,u,0), vec3(0,0,u),
                       vec3(0,0,0), vec3(-32768,-32768,-32768), vec3(u,0,0), vec3(0,u,0),
                       vec3(0,0,u), vec3(0,0,0)}, 0});
    // Extreme axis components and all-ones / all-zeros words.
    rows.push_back('{'{'1, '1, '1, '1, '1, '0, '1, '1, '1, '1}, -1});
    rows.push_back('{'{vec3(-32768,0,0), vec3(-32768,-32768,-32768), vec3(32767,32767,32767),
                       vec3(-32768,32767,0), vec3(65535,0,65535), vec3(32767,0,0),
                       vec3(32767,-32768,32767), vec3(-32768,32767,-32768), vec3(0,0,-32768),
                       vec3(0,65535,0)}, -1});
    // Box B rotated 45 degrees (about z, about y in the last row) near box A, both outcomes.
    rows.push_back('{'{vec3(0,0,0), vec3(u,0,0), vec3(0,u,0), vec3(0,0,u), vec3(h,h,h),
                       vec3(600,0,0), vec3(11585,11585,0), vec3(-11585,11585,0),
                       vec3(0,0,u), vec3(h,h,h)}, -1});
    rows.push_back('{'{vec3(0,0,0), vec3(u,0,0), vec3(0,u,0), vec3(0,0,u), vec3(h,h,h),
                       vec3(700,0,0), vec3(11585,11585,0), vec3(-11585,11585,0),
                       vec3(0,0,u), vec3(h,h,h)}, -1});
    rows.push_back('{'{vec3(0,0,0), vec3(u,0,0), vec3(0,u,0), vec3(0,0,u), vec3(h,h,h),
                       vec3(400,400,600), vec3(11585,0,11585), vec3(0,u,0),
                       vec3(-11585,0,11585), vec3(h,2*h,h)}, -1});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      p.w = rows[i].w;
      send_checked(p, rows[i].want);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 2) begin
        pair_if.valid <= 1'b0;
        @(posedge clk_i);
        wait (overlap_q.size() == 0);
      end
      if ($urandom_range(0, 4) == 0) begin
        foreach (p.w[k]) p.w[k] = rand_word();
      end else begin
        p.w[0] = vec3($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                      $urandom_range(0, 2000) - 1000);
        p.w[5] = vec3($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                      $urandom_range(0, 2000) - 1000);
        for (int k = 0; k < 3; k++) begin
          p.w[1+k] = rand_unit_axis(k);
          p.w[6+k] = rand_unit_axis((k + n) % 3);
        end
        p.w[4] = vec3($urandom_range(0, 700), $urandom_range(0, 700), $urandom_range(0, 700));
        p.w[9] = vec3($urandom_range(0, 700), $urandom_range(0, 700), $urandom_range(0, 700));
      end
      send_checked(p, -1);
    end
    pair_if.valid <= 1'b0;

    wait (overlap_q.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("Checked %0d box pairs (%0d overlapping) with random gaps and output stalls.",
             flags_seen, overlaps_seen);
    if (errors == 0 && overlap_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
